// File: hw/rtl/rf3_pkg.sv
// rf3_pkg: shared types and constants of the 3x3 rank filter
// used by rank_filter_3x3 and rf3_checker; depends on nothing else

package rf3_pkg;

    // frame size limits; the width limit also sizes the line stores
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_DIM        = 3;

    // configuration register layout
    localparam int CFG_W   = 11;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE         = 2'd2;

    localparam logic [CFG_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RST = 11'd480;

    localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RST = MODE_MED;

    // divide by three: floor(s * 683 / 2048) is exact for s up to 765
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       drain;
    } rf3_pix_t;

    typedef struct packed {
        logic [7:0] gray_out;
        logic       last_in_frame;
    } rf3_res_t;

endpackage

// File: hw/rtl/rank_filter_3x3.sv
// rank_filter_3x3: streaming 3x3 min / median / max filter on the gray image
// depends on rf3_pkg; holds the two line stores, the window and the apb registers
// throughput: one item per cycle while m_ready is high; each line store takes one read and one write a cycle
// output path: m_valid rises once the item that completes a result has passed the input reg,
//   the window reg and the result reg; in stream terms results lag the input by one row plus one pixel
// reset: synchronous active-low aresetn clears counters, valids, window; loads 640x480 median
module rank_filter_3x3
    import rf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // pixel input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  rf3_pix_t          s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output rf3_res_t          m_data,
    // apb configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // column index into the line stores
    localparam int AW   = $clog2(MAX_WIDTH);
    // input row counts up to height+1 during the flush
    localparam int RW   = $clog2(MAX_HEIGHT + 2);
    // output row stays below height
    localparam int ORW  = $clog2(MAX_HEIGHT);
    // common width for size compares
    localparam int DIM_W = ($clog2(MAX_WIDTH + 2) > $clog2(MAX_HEIGHT + 2)) ?
                           $clog2(MAX_WIDTH + 2) : $clog2(MAX_HEIGHT + 2);
    localparam int CW   = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;
    localparam int SUM_W  = 10;
    localparam int PROD_W = 20;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;
    logic [MODE_W-1:0] mode_reg;

    logic       cfg_wr;
    logic       size_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // a size write restarts the frame
    assign size_wr = cfg_wr && ((paddr[3:2] == REG_FRAME_WIDTH) ||
                                (paddr[3:2] == REG_FRAME_HEIGHT));

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            REG_MODE:         prdata = DATA_W'(mode_reg);
            default:          prdata = '0;
        endcase
    end

    // effective frame size, clamped to 3..max
    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;

    always_comb begin
        if (CW'(frame_width_reg) < CW'(MIN_DIM)) begin
            w_eff = CW'(MIN_DIM);
        end else if (CW'(frame_width_reg) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(frame_width_reg);
        end
        if (CW'(frame_height_reg) < CW'(MIN_DIM)) begin
            h_eff = CW'(MIN_DIM);
        end else if (CW'(frame_height_reg) > CW'(MAX_HEIGHT)) begin
            h_eff = CW'(MAX_HEIGHT);
        end else begin
            h_eff = CW'(frame_height_reg);
        end
    end

    // ---------------------------------------------------------------
    // pipeline handshake: input reg (s1) -> window reg (s2) -> result reg
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s_accept;
    logic s1_adv;
    logic s2_adv;

    // s2 holds only items that give a result; the window may shift only
    // when that result has moved on
    assign s2_adv   = s2_valid_reg && (!out_valid_reg || m_ready);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;

    // ---------------------------------------------------------------
    // position counters, all kept at the input side so that the frame
    // restart on the last result is seen by the very next item
    // ---------------------------------------------------------------
    logic [AW-1:0]  in_col_reg,  in_col_next;
    logic [RW-1:0]  in_row_reg,  in_row_next;
    logic [AW-1:0]  out_col_reg, out_col_next;
    logic [ORW-1:0] out_row_reg, out_row_next;

    logic [CW-1:0] col_ext;
    logic [CW-1:0] row_ext;
    logic [CW-1:0] ocol_ext;
    logic [CW-1:0] orow_ext;
    logic          emit;
    logic          interior;
    logic          last;

    always_comb begin
        col_ext  = CW'(in_col_reg);
        row_ext  = CW'(in_row_reg);
        ocol_ext = CW'(out_col_reg);
        orow_ext = CW'(out_row_reg);

        // nothing comes out until the window center is row 0 column 0
        emit = (row_ext >= CW'(2)) || ((row_ext == CW'(1)) && (col_ext >= CW'(1)));
        interior = (orow_ext >= CW'(1)) && ((orow_ext + CW'(1)) < h_eff) &&
                   (ocol_ext >= CW'(1)) && ((ocol_ext + CW'(1)) < w_eff);
        last = ((orow_ext + CW'(1)) >= h_eff) && ((ocol_ext + CW'(1)) >= w_eff);

        in_col_next  = in_col_reg + AW'(1);
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if ((col_ext + CW'(1)) >= w_eff) begin
            in_col_next = '0;
            // input row saturates at height+1 during the flush
            if (row_ext < (h_eff + CW'(1))) begin
                in_row_next = in_row_reg + RW'(1);
            end
        end

        if (emit) begin
            if (last) begin
                // end of frame: every counter back to zero
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if ((ocol_ext + CW'(1)) >= w_eff) begin
                out_col_next = '0;
                out_row_next = out_row_reg + ORW'(1);
            end else begin
                out_col_next = out_col_reg + AW'(1);
            end
        end
    end

    // gray conversion; drain items and flush rows give zero
    logic [SUM_W-1:0]  rgb_sum;
    logic [PROD_W-1:0] rgb_prod;
    logic [7:0]        gray_in;

    always_comb begin
        rgb_sum  = SUM_W'(s_data.red) + SUM_W'(s_data.green) + SUM_W'(s_data.blue);
        rgb_prod = PROD_W'(rgb_sum) * PROD_W'(DIV3_MUL);
        if (!s_data.drain && (row_ext < h_eff)) begin
            gray_in = rgb_prod[DIV3_SHIFT +: 8];
        end else begin
            gray_in = '0;
        end
    end

    // ---------------------------------------------------------------
    // stage 1 payload
    // ---------------------------------------------------------------
    logic [7:0]    s1_gray_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_emit_reg;
    logic          s1_interior_reg;
    logic          s1_last_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_gray_reg     <= gray_in;
            s1_addr_reg     <= in_col_reg;
            s1_emit_reg     <= emit;
            s1_interior_reg <= interior;
            s1_last_reg     <= last;
        end
    end

    // ---------------------------------------------------------------
    // line stores: read at accept, written when the item leaves stage 1
    // ---------------------------------------------------------------
    logic [7:0] upper_mem  [MAX_WIDTH];
    logic [7:0] middle_mem [MAX_WIDTH];
    logic [7:0] upper_rd_reg;
    logic [7:0] middle_rd_reg;
    logic       fwd;

    // the item after the last result goes back to column zero, which the
    // item leaving stage 1 writes in the same cycle: take its data directly
    assign fwd = s1_adv && (s1_addr_reg == in_col_reg);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            upper_rd_reg  <= fwd ? middle_rd_reg : upper_mem[in_col_reg];
            middle_rd_reg <= fwd ? s1_gray_reg   : middle_mem[in_col_reg];
        end
        if (s1_adv) begin
            upper_mem[s1_addr_reg]  <= middle_rd_reg;
            middle_mem[s1_addr_reg] <= s1_gray_reg;
        end
    end

    // ---------------------------------------------------------------
    // window and stage 2 flags
    // ---------------------------------------------------------------
    // win_reg[0..2] top row, [3..5] middle row, [6..8] bottom row, oldest left
    logic [8:0][7:0] win_reg;
    logic            s2_interior_reg;
    logic            s2_last_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            s2_interior_reg <= s1_interior_reg;
            s2_last_reg     <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // rank of the window: sort each row, then combine row extremes
    // ---------------------------------------------------------------
    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [2:0][7:0] row_lo;
    logic [2:0][7:0] row_mid;
    logic [2:0][7:0] row_hi;
    logic [7:0]      win_min;
    logic [7:0]      win_max;
    logic [7:0]      win_med;
    logic [7:0]      rank_val;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_lo[r]  = min2(min2(win_reg[3*r], win_reg[3*r+1]), win_reg[3*r+2]);
            row_hi[r]  = max2(max2(win_reg[3*r], win_reg[3*r+1]), win_reg[3*r+2]);
            row_mid[r] = med3(win_reg[3*r], win_reg[3*r+1], win_reg[3*r+2]);
        end
        win_min = min2(min2(row_lo[0], row_lo[1]), row_lo[2]);
        win_max = max2(max2(row_hi[0], row_hi[1]), row_hi[2]);
        // median of nine: median of (max of lows, median of mids, min of highs)
        win_med = med3(max2(max2(row_lo[0], row_lo[1]), row_lo[2]),
                       med3(row_mid[0], row_mid[1], row_mid[2]),
                       min2(min2(row_hi[0], row_hi[1]), row_hi[2]));
        case (mode_reg)
            MODE_MIN: rank_val = win_min;
            MODE_MED: rank_val = win_med;
            default:  rank_val = win_max;
        endcase
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    rf3_res_t out_data_reg;

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            // border pixels pass their own gray through
            out_data_reg.gray_out      <= s2_interior_reg ? rank_val : win_reg[4];
            out_data_reg.last_in_frame <= s2_last_reg;
        end
    end

    assign m_data = out_data_reg;

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            mode_reg         <= MODE_RST;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            win_reg          <= '0;
        end else begin
            // register writes
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                    REG_MODE:         mode_reg         <= pwdata[MODE_W-1:0];
                    default:          ;
                endcase
            end

            // position counters
            if (size_wr) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else if (s_accept) begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end

            // stage valids
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv && s1_emit_reg) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            // window shifts by one column for every item
            if (s1_adv) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= upper_rd_reg;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= middle_rd_reg;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= s1_gray_reg;
            end
        end
    end

endmodule

// File: hw/rtl/rf3_checker.sv
// rf3_checker: port-level assertions for rank_filter_3x3, bound into every rank_filter_3x3 instance
// depends on rf3_pkg for the payload type and register indexes

module rf3_checker
    import rf3_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input rf3_res_t          m_data,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed or dropped while stalled");

    // no result out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // apb never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

    // a size register reads back what was written
    a_size_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite &&
         ((paddr[3:2] == REG_FRAME_WIDTH) || (paddr[3:2] == REG_FRAME_HEIGHT)))
        |=> (!(psel && !pwrite && (paddr[3:2] == $past(paddr[3:2]))) ||
             (prdata == DATA_W'($past(pwdata[CFG_W-1:0])))))
        else $error("size register readback mismatch");

    // the mode register reads back what was written
    a_mode_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && (paddr[3:2] == REG_MODE))
        |=> (!(psel && !pwrite && (paddr[3:2] == REG_MODE)) ||
             (prdata == DATA_W'($past(pwdata[MODE_W-1:0])))))
        else $error("mode register readback mismatch");

endmodule

bind rank_filter_3x3 rf3_checker u_rf3_checker (.*);
